// ===== design/lads_pkg.sv =====
// ----------------------------------------------------------------------------
// lads_pkg
// Shared types, constants and scoring functions for the local alignment
// scorer with two-piece affine gaps.
// ----------------------------------------------------------------------------
package lads_pkg;

    localparam int MAX_LEN    = 512;
    localparam int SCORE_BITS = 16;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int ADDR_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int BEST_W     = 15;
    localparam int POS_W      = 10;
    localparam int OUT_W      = 40;
    localparam int OUT_PAD    = OUT_W - BEST_W - 2 * POS_W;
    localparam int BEST_MAX   = 32767;

    localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS - 1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS - 1){1'b0}}};

    localparam logic [2:0] REG_SUB_LOW    = 3'd0;
    localparam logic [2:0] REG_SUB_HIGH   = 3'd1;
    localparam logic [2:0] REG_SHORT_OPEN = 3'd2;
    localparam logic [2:0] REG_SHORT_EXT  = 3'd3;
    localparam logic [2:0] REG_LONG_OPEN  = 3'd4;
    localparam logic [2:0] REG_LONG_EXT   = 3'd5;
    localparam logic [2:0] REG_ALIGN_MODE = 3'd6;

    localparam logic [2:0] NT_A = 3'd0;
    localparam logic [2:0] NT_C = 3'd1;
    localparam logic [2:0] NT_G = 3'd2;
    localparam logic [2:0] NT_T = 3'd3;
    localparam logic [2:0] NT_N = 3'd4;

    typedef logic signed [SCORE_BITS-1:0] score_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       rbase;
        score_t           m_sc;
        score_t           is_sc;
        score_t           il_sc;
        score_t           hdiag;
        score_t           best_h;
        logic [CNT_W-1:0] best_q;
        score_t           end_h;
    } row_t;

    typedef struct packed {
        logic [63:0]       sub_low;
        logic [23:0]       sub_high;
        logic signed [7:0] short_open;
        logic signed [7:0] short_ext;
        logic signed [7:0] long_open;
        logic signed [7:0] long_ext;
    } score_cfg_t;

    function automatic logic [2:0] encode(input logic [7:0] c);
        case (c)
            8'h41, 8'h61: encode = NT_A;
            8'h43, 8'h63: encode = NT_C;
            8'h47, 8'h67: encode = NT_G;
            8'h54, 8'h74: encode = NT_T;
            default:      encode = NT_N;
        endcase
    endfunction

    function automatic logic [2:0] compl_nt(input logic [2:0] nt, input logic comp);
        if (comp && !nt[2])
            compl_nt = {1'b0, ~nt[1:0]};
        else
            compl_nt = nt;
    endfunction

    function automatic logic signed [7:0] sub_score(input logic [2:0] q, input logic [2:0] r,
                                                    input logic [63:0] lo,
                                                    input logic [23:0] hi);
        if (q[2] || r[2])
            sub_score = hi[23:16];
        else begin
            case ({q[1:0], r[1:0]})
                4'b0000:          sub_score = lo[7:0];
                4'b0001, 4'b0100: sub_score = lo[15:8];
                4'b0010, 4'b1000: sub_score = lo[23:16];
                4'b0011, 4'b1100: sub_score = lo[31:24];
                4'b0101:          sub_score = lo[39:32];
                4'b0110, 4'b1001: sub_score = lo[47:40];
                4'b0111, 4'b1101: sub_score = lo[55:48];
                4'b1010:          sub_score = lo[63:56];
                4'b1011, 4'b1110: sub_score = hi[7:0];
                default:          sub_score = hi[15:8];
            endcase
        end
    endfunction

    function automatic score_t sat_add(input score_t a, input logic signed [7:0] b);
        logic signed [SCORE_BITS:0] s;
        s = (SCORE_BITS + 1)'(a) + (SCORE_BITS + 1)'(b);
        if (s > SMAX)
            sat_add = SMAX;
        else if (s < SMIN)
            sat_add = SMIN;
        else
            sat_add = SCORE_BITS'(s);
    endfunction

    function automatic score_t pick(input score_t open_sc, input score_t ext_sc);
        pick = (open_sc > ext_sc) ? open_sc : ext_sc;
    endfunction

endpackage

// ===== design/lads_cell.sv =====
// ----------------------------------------------------------------------------
// lads_cell
// One column of the alignment matrix: holds its query base and the column
// scores of the previous row, computes one cell per row and hands the row
// values on to the next column.
// ----------------------------------------------------------------------------
module lads_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        init,
    input  logic                        shift_en,
    input  logic [2:0]                  base_in,
    output logic [2:0]                  base_out,
    input  logic [lads_pkg::CNT_W-1:0]  idx,
    input  logic [lads_pkg::CNT_W-1:0]  qcount,
    input  lads_pkg::score_cfg_t        cfg,
    input  lads_pkg::row_t              row_in,
    output lads_pkg::row_t              row_out
);

    logic [2:0]       base_reg;
    lads_pkg::score_t h_reg, m_reg, d_reg, dl_reg;
    lads_pkg::row_t   row_reg, row_next;

    logic signed [7:0] sub;
    lads_pkg::score_t  mv, dv, iv, dlv, ilv, hv;
    logic              active;
    logic [lads_pkg::CNT_W-1:0] col;

    always_comb
    begin
        sub    = lads_pkg::sub_score(base_reg, row_in.rbase, cfg.sub_low, cfg.sub_high);
        mv     = lads_pkg::sat_add(row_in.hdiag, sub);
        dv     = lads_pkg::pick(lads_pkg::sat_add(m_reg, cfg.short_open),
                                lads_pkg::sat_add(d_reg, cfg.short_ext));
        iv     = lads_pkg::pick(lads_pkg::sat_add(row_in.m_sc, cfg.short_open),
                                lads_pkg::sat_add(row_in.is_sc, cfg.short_ext));
        dlv    = lads_pkg::pick(lads_pkg::sat_add(m_reg, cfg.long_open),
                                lads_pkg::sat_add(dl_reg, cfg.long_ext));
        ilv    = lads_pkg::pick(lads_pkg::sat_add(row_in.m_sc, cfg.long_open),
                                lads_pkg::sat_add(row_in.il_sc, cfg.long_ext));
        if (mv >= 0 && mv >= dv && mv >= dlv && mv >= iv && mv >= ilv)
            hv = mv;
        else if (dv >= 0 && dv >= dlv && dv >= iv && dv >= ilv)
            hv = dv;
        else if (dlv >= 0 && dlv >= iv && dlv >= ilv)
            hv = dlv;
        else if (iv >= 0 && iv >= ilv)
            hv = iv;
        else if (ilv >= 0)
            hv = ilv;
        else
            hv = '0;

        active   = idx < qcount;
        col      = idx + 1'b1;
        row_next = row_in;
        if (active)
        begin
            row_next.m_sc  = mv;
            row_next.is_sc = iv;
            row_next.il_sc = ilv;
            row_next.hdiag = h_reg;
            if (hv >= row_in.best_h)
            begin
                row_next.best_h = hv;
                row_next.best_q = col;
            end
            if (col == qcount)
                row_next.end_h = hv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else
            row_reg <= row_next;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
            base_reg <= base_in;
        if (init)
        begin
            h_reg  <= '0;
            m_reg  <= '0;
            d_reg  <= lads_pkg::SMIN;
            dl_reg <= lads_pkg::SMIN;
        end
        else if (row_in.valid && active)
        begin
            h_reg  <= hv;
            m_reg  <= mv;
            d_reg  <= dv;
            dl_reg <= dlv;
        end
    end

    assign base_out = base_reg;
    assign row_out  = row_reg;

endmodule

// ===== design/local_align_dual_affine_score.sv =====
// ----------------------------------------------------------------------------
// local_align_dual_affine_score
// Local alignment scorer with two-piece affine gaps on a row of column cells.
// ----------------------------------------------------------------------------
// Bases are taken one per cycle while the block is idle and stored in the
// reference and query memories. The final base (tlast) starts the alignment:
// the query is shifted into the cell row, then reference bases enter the first
// cell one per cycle and each row sweeps across all MAX_LEN cells as a wavefront.
// No base is taken until the result has moved into the output register, and
// that move waits while an earlier result is still held there. The result then
// waits in the output register while the next bases load.
module local_align_dual_affine_score (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // base_char
    input  logic        s_tuser,   // seq_is_query
    input  logic        s_tlast,   // last_base
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // best_score[14:0], ref_end_pos[24:15], query_end_pos[34:25]
    output logic        m_tuser,   // length_overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_QLOAD  = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int CW = lads_pkg::CNT_W;
    localparam int AW = lads_pkg::ADDR_W;
    localparam int N  = lads_pkg::MAX_LEN;

    logic [1:0]  state_reg, state_next;
    logic [CW-1:0] ref_count_reg, ref_count_next, query_count_reg, query_count_next;
    logic        ovf_reg, ovf_next;
    logic [CW-1:0] k_reg, k_next, rows_reg, rows_next;
    logic        rdv_reg, rdv_next;
    lads_pkg::score_t gbest_reg, gbest_next, gend_reg, gend_next;
    logic [CW-1:0] gbi_reg, gbi_next, gbj_reg, gbj_next;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        out_ovf_reg, out_ovf_next;

    lads_pkg::score_cfg_t cfg_reg;
    logic [4:0]  mode_reg;

    logic [2:0]  ref_mem [0:N-1];
    logic [2:0]  query_mem [0:N-1];
    logic [2:0]  r_rdata_reg, q_rdata_reg;
    logic [AW-1:0] r_raddr, q_raddr;

    logic        in_fire, start, issue, shift_en;
    logic [2:0]  code;
    lads_pkg::row_t chain [0:N];
    logic [2:0]  bchain [0:N];
    lads_pkg::row_t tail;

    logic signed [32:0] sc_ext;
    logic [CW-1:0] rpos, qpos;
    lads_pkg::score_t score_sel;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign start     = in_fire && s_tlast;
    assign code      = lads_pkg::encode(s_tdata);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            mode_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lads_pkg::REG_SUB_LOW:    cfg_reg.sub_low    <= cfg_data;
                lads_pkg::REG_SUB_HIGH:   cfg_reg.sub_high   <= cfg_data[23:0];
                lads_pkg::REG_SHORT_OPEN: cfg_reg.short_open <= cfg_data[7:0];
                lads_pkg::REG_SHORT_EXT:  cfg_reg.short_ext  <= cfg_data[7:0];
                lads_pkg::REG_LONG_OPEN:  cfg_reg.long_open  <= cfg_data[7:0];
                lads_pkg::REG_LONG_EXT:   cfg_reg.long_ext   <= cfg_data[7:0];
                lads_pkg::REG_ALIGN_MODE: mode_reg           <= cfg_data[4:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        q_raddr = mode_reg[2] ? k_reg[AW-1:0] : AW'(query_count_reg - k_reg - 1'b1);
        r_raddr = mode_reg[4] ? AW'(ref_count_reg - k_reg - 1'b1) : k_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !s_tuser && ref_count_reg < CW'(N))
            ref_mem[ref_count_reg[AW-1:0]] <= code;
        r_rdata_reg <= ref_mem[r_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && s_tuser && query_count_reg < CW'(N))
            query_mem[query_count_reg[AW-1:0]] <= code;
        q_rdata_reg <= query_mem[q_raddr];
    end

    assign shift_en  = (state_reg == ST_QLOAD) && rdv_reg;
    assign bchain[0] = lads_pkg::compl_nt(q_rdata_reg, mode_reg[1]);

    always_comb
    begin
        chain[0]        = '0;
        chain[0].valid  = (state_reg == ST_RUN) && rdv_reg;
        chain[0].rbase  = lads_pkg::compl_nt(r_rdata_reg, mode_reg[3]);
        chain[0].is_sc  = lads_pkg::SMIN;
        chain[0].il_sc  = lads_pkg::SMIN;
    end

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        lads_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .init     (start),
            .shift_en (shift_en),
            .base_in  (bchain[j]),
            .base_out (bchain[j+1]),
            .idx      (CW'(j)),
            .qcount   (query_count_reg),
            .cfg      (cfg_reg),
            .row_in   (chain[j]),
            .row_out  (chain[j+1])
        );
    end

    assign tail = chain[N];

    always_comb
    begin
        state_next       = state_reg;
        ref_count_next   = ref_count_reg;
        query_count_next = query_count_reg;
        ovf_next         = ovf_reg;
        k_next           = k_reg;
        rows_next        = rows_reg;
        rdv_next         = 1'b0;
        gbest_next       = gbest_reg;
        gend_next        = gend_reg;
        gbi_next         = gbi_reg;
        gbj_next         = gbj_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_ovf_next     = out_ovf_reg;
        issue            = 1'b0;

        if (mode_reg[0])
        begin
            score_sel = gend_reg;
            rpos      = ref_count_reg - 1'b1;
            qpos      = query_count_reg - 1'b1;
        end
        else
        begin
            score_sel = gbest_reg;
            rpos      = gbi_reg - 1'b1;
            qpos      = gbj_reg - 1'b1;
        end
        sc_ext = 33'(score_sel);
        if (sc_ext < 0)
            sc_ext = '0;
        else if (sc_ext > 33'(lads_pkg::BEST_MAX))
            sc_ext = 33'(lads_pkg::BEST_MAX);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser)
                    begin
                        if (query_count_reg < CW'(N))
                            query_count_next = query_count_reg + 1'b1;
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (ref_count_reg < CW'(N))
                            ref_count_next = ref_count_reg + 1'b1;
                        else
                            ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_QLOAD;
                        k_next     = '0;
                        gbest_next = '0;
                        gend_next  = '0;
                        gbi_next   = '0;
                        gbj_next   = '0;
                    end
                end
            end
            ST_QLOAD:
            begin
                issue    = k_reg < query_count_reg;
                rdv_next = issue;
                if (issue)
                    k_next = k_reg + 1'b1;
                else if (!rdv_reg)
                begin
                    state_next = ST_RUN;
                    k_next     = '0;
                    rows_next  = '0;
                end
            end
            ST_RUN:
            begin
                issue    = k_reg < ref_count_reg;
                rdv_next = issue;
                if (issue)
                    k_next = k_reg + 1'b1;
                if (tail.valid)
                begin
                    rows_next = rows_reg + 1'b1;
                    gend_next = tail.end_h;
                    if (query_count_reg != '0 && tail.best_h >= gbest_reg)
                    begin
                        gbest_next = tail.best_h;
                        gbi_next   = rows_reg + 1'b1;
                        gbj_next   = tail.best_q;
                    end
                end
                if (rows_reg == ref_count_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_data_next    = {{lads_pkg::OUT_PAD{1'b0}},
                                        lads_pkg::POS_W'($signed(qpos)),
                                        lads_pkg::POS_W'($signed(rpos)),
                                        sc_ext[lads_pkg::BEST_W-1:0]};
                    out_ovf_next     = ovf_reg;
                    ref_count_next   = '0;
                    query_count_next = '0;
                    ovf_next         = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ref_count_reg   <= '0;
            query_count_reg <= '0;
            ovf_reg         <= 1'b0;
            k_reg           <= '0;
            rows_reg        <= '0;
            rdv_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ref_count_reg   <= ref_count_next;
            query_count_reg <= query_count_next;
            ovf_reg         <= ovf_next;
            k_reg           <= k_next;
            rows_reg        <= rows_next;
            rdv_reg         <= rdv_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gbest_reg    <= gbest_next;
        gend_reg     <= gend_next;
        gbi_reg      <= gbi_next;
        gbj_reg      <= gbj_next;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

`ifndef SYNTHESIS
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && (!out_valid_reg || m_tready))
        |=> (out_valid_reg && ref_count_reg == '0 && query_count_reg == '0 && !ovf_reg))
        else $error("finish did not post result and clear counts");

    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rows_reg <= ref_count_reg))
        else $error("more rows drained than reference bases");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ref_count_reg <= CW'(N) && query_count_reg <= CW'(N)))
        else $error("base count beyond store depth");

    a_no_row_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_QLOAD) |-> !chain[0].valid)
        else $error("row entered cell chain outside sweep");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Local alignment scorer testbench
// Streams reference and query bases into the block under random valid and
// ready gaps, predicts every alignment result with an independent two-piece
// affine gap scorer, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [14:0] score;
        logic [9:0]  rpos;
        logic [9:0]  qpos;
        logic        ovf;
    } align_result_t;

    class align_scoreboard;
        logic [87:0]       sub_tbl;
        logic signed [7:0] s_open, s_ext, l_open, l_ext;
        logic [4:0]        mode;
        logic [2:0]        ref_nt[lads_pkg::MAX_LEN];
        logic [2:0]        qry_nt[lads_pkg::MAX_LEN];
        int                ref_len, qry_len;
        bit                ovf;
        align_result_t     pending_results[$];
        int                errors;

        function new();
            sub_tbl = '0;
            s_open = 0; s_ext = 0; l_open = 0; l_ext = 0;
            mode = 0; ref_len = 0; qry_len = 0; ovf = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                lads_pkg::REG_SUB_LOW:    sub_tbl[63:0]  = d;
                lads_pkg::REG_SUB_HIGH:   sub_tbl[87:64] = d[23:0];
                lads_pkg::REG_SHORT_OPEN: s_open = d[7:0];
                lads_pkg::REG_SHORT_EXT:  s_ext  = d[7:0];
                lads_pkg::REG_LONG_OPEN:  l_open = d[7:0];
                lads_pkg::REG_LONG_EXT:   l_ext  = d[7:0];
                lads_pkg::REG_ALIGN_MODE: mode   = d[4:0];
                default: ;
            endcase
        endfunction

        function logic [2:0] base_code(logic [7:0] c);
            case (c)
                "A", "a": return lads_pkg::NT_A;
                "C", "c": return lads_pkg::NT_C;
                "G", "g": return lads_pkg::NT_G;
                "T", "t": return lads_pkg::NT_T;
                default:  return lads_pkg::NT_N;
            endcase
        endfunction

        function int clamp(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function int pair_score(logic [2:0] a, logic [2:0] b);
            int lo, hi, k;
            int offs[4] = '{0, 4, 7, 9};
            if (a[2] || b[2])
                k = 10;
            else begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                k = offs[lo] + hi - lo;
            end
            return $signed(sub_tbl[8*k +: 8]);
        endfunction

        function logic [2:0] oriented(logic [2:0] nt, bit comp);
            return (comp && !nt[2]) ? 3'(3 - nt) : nt;
        endfunction

        function void score_alignment();
            int rh[lads_pkg::MAX_LEN+1], rm[lads_pkg::MAX_LEN+1], rd[lads_pkg::MAX_LEN+1];
            int ri[lads_pkg::MAX_LEN+1], rD[lads_pkg::MAX_LEN+1], rI[lads_pkg::MAX_LEN+1];
            int best, bi, bj, last_h, hd, lm, li, lI, uh, um;
            int mv, dv, iv, Dv, Iv, hv, sc, a, b;
            logic [2:0] rn, qn;
            align_result_t res;
            best = 0; bi = 0; bj = 0; last_h = 0;
            for (int q = 0; q <= qry_len; q++)
            begin
                rh[q] = 0; rm[q] = 0;
                rd[q] = -32768; ri[q] = -32768; rD[q] = -32768; rI[q] = -32768;
            end
            for (int r = 1; r <= ref_len; r++)
            begin
                rn = oriented(ref_nt[mode[4] ? ref_len - r : r - 1], mode[3]);
                hd = 0; lm = 0; li = -32768; lI = -32768;
                for (int q = 1; q <= qry_len; q++)
                begin
                    qn = oriented(qry_nt[mode[2] ? qry_len - q : q - 1], mode[1]);
                    uh = rh[q]; um = rm[q];
                    mv = clamp(hd + pair_score(qn, rn));
                    a = clamp(um + s_open); b = clamp(rd[q] + s_ext); dv = a > b ? a : b;
                    a = clamp(lm + s_open); b = clamp(li + s_ext);    iv = a > b ? a : b;
                    a = clamp(um + l_open); b = clamp(rD[q] + l_ext); Dv = a > b ? a : b;
                    a = clamp(lm + l_open); b = clamp(lI + l_ext);    Iv = a > b ? a : b;
                    if (mv >= 0 && mv >= dv && mv >= Dv && mv >= iv && mv >= Iv) hv = mv;
                    else if (dv >= 0 && dv >= Dv && dv >= iv && dv >= Iv) hv = dv;
                    else if (Dv >= 0 && Dv >= iv && Dv >= Iv) hv = Dv;
                    else if (iv >= 0 && iv >= Iv) hv = iv;
                    else if (Iv >= 0) hv = Iv;
                    else hv = 0;
                    rh[q] = hv; rm[q] = mv; rd[q] = dv; ri[q] = iv; rD[q] = Dv; rI[q] = Iv;
                    hd = uh; lm = mv; li = iv; lI = Iv;
                    if (hv >= best)
                    begin
                        best = hv; bi = r; bj = q;
                    end
                    last_h = hv;
                end
            end
            if (mode[0])
            begin
                sc = last_h; res.rpos = 10'(ref_len - 1); res.qpos = 10'(qry_len - 1);
            end
            else
            begin
                sc = best; res.rpos = 10'(bi - 1); res.qpos = 10'(bj - 1);
            end
            res.score = (sc < 0) ? 15'd0 : 15'(sc);
            res.ovf = ovf;
            pending_results = {pending_results, res};
            ref_len = 0; qry_len = 0; ovf = 0;
        endfunction

        function void note_input(logic [7:0] c, logic is_q, logic lst);
            if (is_q)
            begin
                if (qry_len < lads_pkg::MAX_LEN) qry_nt[qry_len++] = base_code(c);
                else ovf = 1;
            end
            else
            begin
                if (ref_len < lads_pkg::MAX_LEN) ref_nt[ref_len++] = base_code(c);
                else ovf = 1;
            end
            if (lst)
                score_alignment();
        endfunction

        function void check_result(logic [39:0] d, logic u);
            align_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction %h", d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (d[14:0] !== e.score)
            begin
                $error("best_score expected %0d actual %0d", e.score, d[14:0]);
                errors++;
            end
            if (d[24:15] !== e.rpos)
            begin
                $error("ref_end_pos expected %0d actual %0d", $signed(e.rpos), $signed(d[24:15]));
                errors++;
            end
            if (d[34:25] !== e.qpos)
            begin
                $error("query_end_pos expected %0d actual %0d", $signed(e.qpos),
                       $signed(d[34:25]));
                errors++;
            end
            if (u !== e.ovf)
            begin
                $error("length_overflow expected %0d actual %0d", e.ovf, u);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    align_scoreboard sb = new();
    int  send_idle;
    int  recv_idle;
    bit  recv_hold;
    int  base_total;

    local_align_dual_affine_score DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tuser, s_tlast);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
        m_tready <= recv_hold ? 1'b0 : ($urandom_range(99) >= recv_idle);

    task automatic send_base(input logic [7:0] c, input logic is_q, input logic lst);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= is_q;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        base_total++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    task automatic set_scoring(input int kind);
        logic [63:0] lo;
        logic [23:0] hi;
        logic [4:0]  md;
        logic [63:0] gap;
        case (kind)
            0:
            begin
                lo = {8'sd2, -8'sd1, -8'sd1, 8'sd2, -8'sd1, -8'sd1, -8'sd1, 8'sd2};
                hi = {-8'sd1, 8'sd2, -8'sd1};
                md = 5'd0;
            end
            1:
            begin
                lo = {8{8'h7f}}; hi = {3{8'h7f}}; md = 5'd31;
            end
            2:
            begin
                lo = {8{8'h80}}; hi = {3{8'h80}}; md = 5'd0;
            end
            default:
            begin
                lo = {$urandom, $urandom};
                hi = 24'($urandom);
                for (int k = 0; k < 8; k++)
                    if ($urandom_range(1)) lo[8*k +: 8] = 8'($urandom_range(12));
                md = 5'($urandom);
            end
        endcase
        write_reg(lads_pkg::REG_SUB_LOW, lo);
        write_reg(lads_pkg::REG_SUB_HIGH, {40'h0, hi});
        if (kind == 1 || kind == 2)
        begin
            gap = (kind == 1) ? 64'h7f : 64'h80;
            write_reg(lads_pkg::REG_SHORT_OPEN, gap);
            write_reg(lads_pkg::REG_SHORT_EXT, gap);
            write_reg(lads_pkg::REG_LONG_OPEN, gap);
            write_reg(lads_pkg::REG_LONG_EXT, gap);
        end
        else
        begin
            write_reg(lads_pkg::REG_SHORT_OPEN, 64'($unsigned(8'(-$urandom_range(8)))));
            write_reg(lads_pkg::REG_SHORT_EXT, 64'($unsigned(8'(-$urandom_range(4)))));
            write_reg(lads_pkg::REG_LONG_OPEN, 64'($unsigned(8'(-$urandom_range(20)))));
            write_reg(lads_pkg::REG_LONG_EXT,
                      ($urandom_range(9) == 0) ? 64'($urandom_range(255))
                                               : 64'($unsigned(8'(-$urandom_range(2)))));
        end
        write_reg(lads_pkg::REG_ALIGN_MODE, 64'(md));
    endtask

    function automatic logic [7:0] rand_base();
        logic [7:0] nts[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return nts[$urandom_range(7)];
    endfunction

    task automatic run_alignment(input int rlen, input int qlen);
        if (rlen == 0 && qlen == 0)
            qlen = 1;
        for (int r = 0; r < rlen; r++)
            send_base(rand_base(), 1'b0, (qlen == 0) && (r == rlen - 1));
        for (int q = 0; q < qlen; q++)
        begin
            if (q > 0 && $urandom_range(15) == 0)
                send_base(rand_base(), 1'b0, 1'b0);
            send_base(rand_base(), 1'b1, q == qlen - 1);
        end
    endtask

    task automatic random_alignment();
        int rlen, qlen;
        rlen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        qlen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        run_alignment(rlen, qlen);
    endtask

    initial
    begin
        int phase_start;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_idle = 0;
        recv_idle = 0;
        recv_hold = 0;
        base_total = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_scoring(0);
        send_base("A", 1'b1, 1'b1);
        send_base("C", 1'b0, 1'b1);
        send_base("A", 1'b0, 1'b0);
        send_base("c", 1'b0, 1'b0);
        send_base("G", 1'b1, 1'b0);
        send_base("t", 1'b0, 1'b0);
        send_base(8'h00, 1'b1, 1'b0);
        send_base(8'hff, 1'b1, 1'b0);
        send_base("N", 1'b1, 1'b0);
        send_base("g", 1'b1, 1'b0);
        send_base("a", 1'b1, 1'b0);
        send_base("T", 1'b0, 1'b1);
        send_base("G", 1'b0, 1'b0);
        send_base("T", 1'b0, 1'b0);
        send_base("C", 1'b1, 1'b0);
        send_base("G", 1'b1, 1'b0);
        send_base("T", 1'b1, 1'b1);
        drain();

        for (int regime = 0; regime < 3; regime++)
        begin
            send_idle = (regime == 0) ? 26 : (regime == 1) ? 76 : 0;
            recv_idle = (regime == 0) ? 76 : (regime == 1) ? 26 : 0;
            for (int ph = 0; ph < 4; ph++)
            begin
                set_scoring((regime == 0) ? ph : (ph == 0) ? 3 - regime : 3);
                if (regime == 2 && ph == 1)
                begin
                    fork
                        begin
                            recv_hold = 1;
                            repeat (4000) @(posedge clk);
                            recv_hold = 0;
                        end
                    join_none
                end
                if (regime == 1 && ph == 2)
                    run_alignment(3, lads_pkg::MAX_LEN + 3);
                phase_start = base_total;
                while (base_total - phase_start < 70)
                    random_alignment();
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lads_pkg.sv
design/lads_cell.sv
design/local_align_dual_affine_score.sv
tb/sv/testbench.sv
